@@ hdl/fbc_pkg.sv @@
// fbc_pkg: shared types and constants for the fault blink-code led sequencer
// holds the config bundle, controller commands and datapath status
// no dependencies
package fbc_pkg;

    localparam logic [15:0] HEARTBEAT_RESET = 16'd500;
    localparam logic [11:0] BLINK_ON_RESET  = 12'd150;
    localparam logic [11:0] BLINK_OFF_RESET = 12'd150;
    localparam logic [11:0] GAP_RESET       = 12'd1000;

    localparam logic [1:0] REG_HEARTBEAT = 2'd0;
    localparam logic [1:0] REG_BLINK_ON  = 2'd1;
    localparam logic [1:0] REG_BLINK_OFF = 2'd2;
    localparam logic [1:0] REG_GAP       = 2'd3;

    typedef struct packed {
        logic [15:0] beat_period;
        logic [11:0] flash_on;
        logic [11:0] flash_off;
        logic [11:0] gap_ticks;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_ACCEPT = 4'd1,
        CMD_PREP   = 4'd2,
        CMD_SPAN   = 4'd3,
        CMD_SEQ    = 4'd4,
        CMD_CMP    = 4'd5,
        CMD_DIV    = 4'd6,
        CMD_POS    = 4'd7,
        CMD_MOD    = 4'd8,
        CMD_END    = 4'd9,
        CMD_OUT    = 4'd10
    } cmd_t;

    typedef struct packed {
        logic code_zero;
        logic phase_lt_seq;
        logic div_last;
        logic in_span;
        logic mod_ge;
        logic out_free;
        logic latch_zero;
        logic phase_zero;
    } status_t;

endpackage

@@ hdl/fbc_ctrl.sv @@
// fbc_ctrl: sequencing state machine for one tick request
// depends on fbc_pkg (cmd_t, status_t)
module fbc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fbc_pkg::status_t sts,
    output fbc_pkg::cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_PREP = 10'b0000000010,
        S_SPAN = 10'b0000000100,
        S_SEQ  = 10'b0000001000,
        S_CMP  = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_POS  = 10'b0001000000,
        S_MOD  = 10'b0010000000,
        S_END  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = fbc_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = fbc_pkg::CMD_ACCEPT;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd        = fbc_pkg::CMD_PREP;
                state_next = sts.code_zero ? S_OUT : S_SPAN;
            end
            S_SPAN:
            begin
                cmd        = fbc_pkg::CMD_SPAN;
                state_next = S_SEQ;
            end
            S_SEQ:
            begin
                cmd        = fbc_pkg::CMD_SEQ;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd        = fbc_pkg::CMD_CMP;
                state_next = sts.phase_lt_seq ? S_POS : S_DIV;
            end
            S_DIV:
            begin
                cmd = fbc_pkg::CMD_DIV;
                if (sts.div_last)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                cmd        = fbc_pkg::CMD_POS;
                state_next = sts.in_span ? S_MOD : S_END;
            end
            S_MOD:
            begin
                cmd = fbc_pkg::CMD_MOD;
                if (!sts.mod_ge)
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                cmd        = fbc_pkg::CMD_END;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd = fbc_pkg::CMD_OUT;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

@@ hdl/fbc_dpath.sv @@
// fbc_dpath: heartbeat counter, blink sequence state, modulo unit and result register
// depends on fbc_pkg (cfg_t, cmd_t, status_t)
module fbc_dpath (
    input  logic             clk,
    input  logic             rst_n,
    input  fbc_pkg::cfg_t    cfg,
    input  fbc_pkg::cmd_t    cmd,
    output fbc_pkg::status_t sts,
    input  logic [2:0]       fault_code,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             green_led,
    output logic             red_led
);

    logic [2:0]  code_reg,  code_next;
    logic [15:0] beat_reg,  beat_next;
    logic        green_reg, green_next;
    logic [2:0]  latch_reg, latch_next;
    logic [15:0] phase_reg, phase_next;
    logic [12:0] len_reg,   len_next;
    logic [15:0] span_reg,  span_next;
    logic [15:0] seq_reg,   seq_next;
    logic [15:0] pos_reg,   pos_next;
    logic [15:0] dvd_reg,   dvd_next;
    logic [3:0]  cnt_reg,   cnt_next;
    logic        red_reg,   red_next;
    logic        ovld_reg,  ovld_next;
    logic        ogrn_reg,  ogrn_next;
    logic        ored_reg,  ored_next;

    logic [16:0] beat_inc;
    logic [15:0] prod;
    logic [16:0] seq_sum;
    logic [16:0] rem_sh;
    logic [16:0] rem_diff;
    logic [16:0] phase_inc;
    logic        out_free;

    assign beat_inc  = {1'b0, beat_reg} + 17'd1;
    assign prod      = 16'({13'b0, latch_reg} * {3'b0, len_reg});
    assign seq_sum   = {1'b0, span_reg} + {5'b0, cfg.gap_ticks};
    assign rem_sh    = {pos_reg, dvd_reg[15]};
    assign rem_diff  = rem_sh - {1'b0, seq_reg};
    assign phase_inc = {1'b0, phase_reg} + 17'd1;
    assign out_free  = !ovld_reg || out_ready;

    always_comb
    begin
        code_next  = code_reg;
        beat_next  = beat_reg;
        green_next = green_reg;
        latch_next = latch_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        span_next  = span_reg;
        seq_next   = seq_reg;
        pos_next   = pos_reg;
        dvd_next   = dvd_reg;
        cnt_next   = cnt_reg;
        red_next   = red_reg;
        ovld_next  = ovld_reg && !out_ready;
        ogrn_next  = ogrn_reg;
        ored_next  = ored_reg;
        unique case (cmd)
            fbc_pkg::CMD_ACCEPT:
            begin
                code_next = fault_code;
                if (beat_inc >= {1'b0, cfg.beat_period})
                begin
                    beat_next  = 16'd0;
                    green_next = !green_reg;
                end
                else
                begin
                    beat_next = beat_inc[15:0];
                end
            end
            fbc_pkg::CMD_PREP:
            begin
                red_next = 1'b0;
                len_next = {1'b0, cfg.flash_on} + {1'b0, cfg.flash_off};
                if (code_reg == 3'd0)
                begin
                    latch_next = 3'd0;
                    phase_next = 16'd0;
                end
                else if (latch_reg == 3'd0)
                begin
                    latch_next = code_reg;
                    phase_next = 16'd0;
                end
            end
            fbc_pkg::CMD_SPAN:
            begin
                span_next = prod;
            end
            fbc_pkg::CMD_SEQ:
            begin
                seq_next = (seq_sum == 17'd0) ? 16'd1 : seq_sum[15:0];
            end
            fbc_pkg::CMD_CMP:
            begin
                if (phase_reg < seq_reg)
                begin
                    pos_next = phase_reg;
                end
                else
                begin
                    pos_next = 16'd0;
                    dvd_next = phase_reg;
                    cnt_next = 4'd0;
                end
            end
            fbc_pkg::CMD_DIV:
            begin
                // restoring division, one quotient bit per cycle
                pos_next = rem_sh[16] || !rem_diff[16] ? rem_diff[15:0] : rem_sh[15:0];
                dvd_next = {dvd_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
            end
            fbc_pkg::CMD_POS:
            begin
                red_next = 1'b0;
            end
            fbc_pkg::CMD_MOD:
            begin
                if (pos_reg >= {3'b0, len_reg})
                begin
                    pos_next = pos_reg - {3'b0, len_reg};
                end
                else
                begin
                    red_next = (pos_reg < {4'b0, cfg.flash_on});
                end
            end
            fbc_pkg::CMD_END:
            begin
                if (phase_inc >= {1'b0, seq_reg})
                begin
                    phase_next = 16'd0;
                    latch_next = 3'd0;
                end
                else
                begin
                    phase_next = phase_inc[15:0];
                end
            end
            fbc_pkg::CMD_OUT:
            begin
                if (out_free)
                begin
                    ovld_next = 1'b1;
                    ogrn_next = green_reg;
                    ored_next = red_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg  <= 16'd0;
            green_reg <= 1'b0;
            latch_reg <= 3'd0;
            phase_reg <= 16'd0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            beat_reg  <= beat_next;
            green_reg <= green_next;
            latch_reg <= latch_next;
            phase_reg <= phase_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        len_reg  <= len_next;
        span_reg <= span_next;
        seq_reg  <= seq_next;
        pos_reg  <= pos_next;
        dvd_reg  <= dvd_next;
        cnt_reg  <= cnt_next;
        red_reg  <= red_next;
        ogrn_reg <= ogrn_next;
        ored_reg <= ored_next;
    end

    assign sts.code_zero    = (code_reg == 3'd0);
    assign sts.phase_lt_seq = (phase_reg < seq_reg);
    assign sts.div_last     = (cnt_reg == 4'd15);
    assign sts.in_span      = (pos_reg < span_reg) && (len_reg != 13'd0);
    assign sts.mod_ge       = (pos_reg >= {3'b0, len_reg});
    assign sts.out_free     = out_free;
    assign sts.latch_zero   = (latch_reg == 3'd0);
    assign sts.phase_zero   = (phase_reg == 16'd0);

    assign out_valid = ovld_reg;
    assign green_led = ogrn_reg;
    assign red_led   = ored_reg;

endmodule

@@ hdl/fault_blink_code_led_sequencer.sv @@
// fault_blink_code_led_sequencer: top level, apb register file, controller and datapath
// depends on fbc_pkg, fbc_ctrl, fbc_dpath
//
//   port group   dir   handshake               payload
//   tick in      in    in_valid / in_ready     fault_code[2:0]
//   leds out     out   out_valid / out_ready   green_led, red_led
//   apb config   in    psel, penable, pready   paddr[3:0], pwdata, prdata
//
// zero code: accept, prep, out; nonzero code: accept, prep, span, seq,
//   cmp, pos, the blink-modulo loop when in span (one subtract per cycle, up to six, then
//   one compare), end and out; a phase at or beyond the sequence length after
//   a register change also runs the bit-serial remainder unit
// reset clears heartbeat, latch, phase and output valid; registers return to their defaults
// a held result stalls the next request only at its final write
module fault_blink_code_led_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  fault_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        green_led,
    output logic        red_led,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fbc_pkg::cfg_t    cfg_reg;
    fbc_pkg::cmd_t    cmd;
    fbc_pkg::status_t sts;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beat_period <= fbc_pkg::HEARTBEAT_RESET;
            cfg_reg.flash_on    <= fbc_pkg::BLINK_ON_RESET;
            cfg_reg.flash_off   <= fbc_pkg::BLINK_OFF_RESET;
            cfg_reg.gap_ticks   <= fbc_pkg::GAP_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                fbc_pkg::REG_HEARTBEAT: cfg_reg.beat_period <= pwdata[15:0];
                fbc_pkg::REG_BLINK_ON:  cfg_reg.flash_on    <= pwdata[11:0];
                fbc_pkg::REG_BLINK_OFF: cfg_reg.flash_off   <= pwdata[11:0];
                fbc_pkg::REG_GAP:       cfg_reg.gap_ticks   <= pwdata[11:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            fbc_pkg::REG_HEARTBEAT: prdata = {16'd0, cfg_reg.beat_period};
            fbc_pkg::REG_BLINK_ON:  prdata = {20'd0, cfg_reg.flash_on};
            fbc_pkg::REG_BLINK_OFF: prdata = {20'd0, cfg_reg.flash_off};
            fbc_pkg::REG_GAP:       prdata = {20'd0, cfg_reg.gap_ticks};
            default:                prdata = 32'd0;
        endcase
    end

    fbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fbc_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .sts        (sts),
        .fault_code (fault_code),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .green_led  (green_led),
        .red_led    (red_led)
    );

    // one request at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    // an empty latch always sits at phase zero
    a_latch_phase: assert property (@(posedge clk) disable iff (!rst_n)
        sts.latch_zero |-> sts.phase_zero)
        else $error("phase nonzero with no latched code");

    // a new result only appears at the end of a busy request
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result produced without a request in flight");

endmodule
